### design/prbt_pkg.sv
// Package for the pair ratio band trader: widths, register indexes, position codes
// and the request and response structs of the shared divider.
// No dependencies.
`default_nettype none
package prbt_pkg;

    localparam int unsigned PRICE_W     = 24;
    localparam int unsigned RATIO_W     = 32;
    localparam int unsigned WORTH_W     = 48;
    localparam int unsigned SQ_W        = 36;
    localparam int unsigned POS_W       = 2;
    localparam int unsigned BAND_W      = 8;
    localparam int unsigned K2_W        = 16;
    localparam int unsigned DIVD_W      = 56;
    localparam int unsigned DIVS_W      = 24;
    localparam int unsigned REL_W       = 56;
    localparam int unsigned FAC_W       = 57;
    localparam int unsigned ACC_W       = 59;
    localparam int unsigned RHS_W       = 53;
    localparam int unsigned LHS_W       = 44;
    localparam int unsigned RATIO_FRAC  = 28;
    localparam int unsigned REL_FRAC    = 32;
    localparam int unsigned WORTH_FRAC  = 16;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 88;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WORTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_MULTIPLE = 2'd1;

    localparam logic [POS_W-1:0] POS_FLAT    = 2'd0;
    localparam logic [POS_W-1:0] POS_LONG_A  = 2'd1;
    localparam logic [POS_W-1:0] POS_SHORT_A = 2'd2;

    localparam logic [CFG_DATA_W-1:0] INIT_WORTH_RST = 16'd1000;
    localparam logic [BAND_W-1:0]     BAND_RST       = 8'd32;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

### design/prbt_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on prbt_pkg for widths and the request and response structs.
`default_nettype none
module prbt_div (
    input  logic               clk,
    input  logic               rst_n,
    input  prbt_pkg::div_req_t req,
    output prbt_pkg::div_rsp_t rsp
);
    import prbt_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIVD_W + 1);

    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dsr_reg, dsr_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              qbit;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        qbit      = (trial >= {1'b0, dsr_reg});
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            dsr_next = req.divisor;
            quo_next = req.dividend;
            cnt_next = CNT_W'(DIVD_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = qbit ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quo_next  = {quo_reg[DIVD_W-2:0], qbit};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = (cnt_reg != '0);
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

### design/prbt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module prbt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 30
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### design/pair_ratio_band_trader_core.sv
// Pair ratio band trader: ratio ring, worth update and band decision under one sequencer.
// Depends on prbt_pkg, prbt_div and prbt_ram.
// A warm-up word needs one divider pass; a decision word needs one pass when flat and
// three passes (ratio, relative a, relative b) with a held position.
// One word is in work at a time; the next is taken in the cycle after the result is registered.
// Reset is asynchronous and active low; the ratio ring needs no clearing pass.
`default_nettype none
module pair_ratio_band_trader_core #(
    parameter int unsigned WINDOW = 30
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // price_a [23:0], price_b [47:24]
    input  logic [prbt_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // worth [47:0], position [49:48], ready_res [50], ratio [82:51], zero pad above
    output logic [prbt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [prbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prbt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import prbt_pkg::*;

    localparam int unsigned PTR_W  = $clog2(WINDOW);
    localparam int unsigned FILL_W = $clog2(WINDOW + 1);
    localparam int unsigned RSUM_W = RATIO_W + FILL_W;
    localparam int unsigned SSUM_W = SQ_W + FILL_W;

    // Division by WINDOW runs in 16-bit digits, each by a reciprocal multiply.
    localparam int unsigned CD_CHUNK  = 16;
    localparam int unsigned CD_DW     = 48;
    localparam int unsigned CD_CHUNKS = CD_DW / CD_CHUNK;
    localparam int unsigned CD_T_W    = PTR_W + CD_CHUNK;
    localparam int unsigned CD_SHIFT  = CD_CHUNK + 2 * PTR_W;
    localparam logic [RATIO_W-1:0] CD_RECIP =
        RATIO_W'(((64'd1 << CD_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam logic [CD_T_W-1:0]  CD_DIVISOR = CD_T_W'(WINDOW);
    localparam logic [2:0]         CD_LOAD    = 3'd0;
    localparam logic [2:0]         CD_LAST    = 3'(2 * CD_CHUNKS);

    typedef enum logic [23:0] {
        S_IDLE   = 24'h000001,
        S_RATIO  = 24'h000002,
        S_RELA   = 24'h000004,
        S_RELB   = 24'h000008,
        S_FACT   = 24'h000010,
        S_MW0    = 24'h000020,
        S_MW1    = 24'h000040,
        S_MW2    = 24'h000080,
        S_MW3    = 24'h000100,
        S_MW4    = 24'h000200,
        S_MEAN   = 24'h000400,
        S_EX2    = 24'h000800,
        S_MSQ    = 24'h001000,
        S_DEV2   = 24'h002000,
        S_VAR    = 24'h004000,
        S_K2     = 24'h008000,
        S_RHS0   = 24'h010000,
        S_RHS1   = 24'h020000,
        S_RHS2   = 24'h040000,
        S_DECIDE = 24'h080000,
        S_PUSH0  = 24'h100000,
        S_PUSH1  = 24'h200000,
        S_PUSH2  = 24'h400000,
        S_DONE   = 24'h800000
    } state_t;

    state_t state_reg, state_next;
    logic launch_reg, launch_next;

    logic [CFG_DATA_W-1:0]  init_reg, init_next;
    logic [BAND_W-1:0]      band_reg, band_next;
    logic [PRICE_W-1:0]     a_reg, a_next, b_reg, b_next;
    logic [PRICE_W-1:0]     preva_reg, preva_next, prevb_reg, prevb_next;
    logic [RATIO_W-1:0]     ratio_reg, ratio_next;
    logic [REL_W-1:0]       rela_reg, rela_next, relb_reg, relb_next;
    logic [FAC_W-1:0]       factor_reg, factor_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [RATIO_W-1:0]     mean_reg, mean_next, dev_reg, dev_next;
    logic [SQ_W-1:0]        ex2_reg, ex2_next, msq_reg, msq_next;
    logic [SQ_W-1:0]        dev2_reg, dev2_next, var_reg, var_next;
    logic [SQ_W-1:0]        sqr_reg, sqr_next;
    logic [K2_W-1:0]        k2_reg, k2_next;
    logic [RHS_W-1:0]       rhs_reg, rhs_next;
    logic [2*RATIO_W-1:0]   prod_reg, prod_next;
    logic [WORTH_W-1:0]     worth_reg, worth_next;
    logic [POS_W-1:0]       held_reg, held_next;
    logic                   ready_res_reg, ready_res_next;
    logic [RSUM_W-1:0]      rsum_reg, rsum_next;
    logic [SSUM_W-1:0]      ssum_reg, ssum_next;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [CD_DW-1:0]       cd_num_reg, cd_num_next, cd_quo_reg, cd_quo_next;
    logic [PTR_W-1:0]       cd_rem_reg, cd_rem_next;
    logic [2:0]             cd_step_reg, cd_step_next;

    logic [RATIO_W-1:0]  mul_a, mul_b;
    logic                ram_we;
    logic [RATIO_W-1:0]  old_ratio;
    logic                full;
    logic [FAC_W-1:0]    plus, minus;
    logic [ACC_W-1:0]    wsum;
    logic                outside;
    logic [CD_T_W-1:0]   cd_t, cd_back, cd_rem;
    logic [CD_CHUNK-1:0] cd_digit;
    logic [CD_DW-1:0]    cd_quo;

    div_req_t div_req;
    div_rsp_t div_rsp;

    prbt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    prbt_ram #(
        .WIDTH (RATIO_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ratio_reg),
        .raddr (ptr_reg),
        .rdata (old_ratio)
    );

    assign full = (fill_reg == FILL_W'(WINDOW));

    always_comb
    begin
        div_req.start    = launch_reg;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            S_RATIO:
            begin
                div_req.dividend = DIVD_W'(a_reg) << RATIO_FRAC;
                div_req.divisor  = b_reg;
            end
            S_RELA:
            begin
                div_req.dividend = DIVD_W'(a_reg) << REL_FRAC;
                div_req.divisor  = preva_reg;
            end
            S_RELB:
            begin
                div_req.dividend = DIVD_W'(b_reg) << REL_FRAC;
                div_req.divisor  = prevb_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        plus     = (FAC_W'(1) << REL_FRAC)
                 + FAC_W'((held_reg == POS_LONG_A) ? rela_reg : relb_reg);
        minus    = FAC_W'((held_reg == POS_LONG_A) ? relb_reg : rela_reg);
        wsum     = acc_reg + (ACC_W'(prod_reg[15:0]) << REL_FRAC);
        outside  = (RHS_W'({dev2_reg, 8'b0}) > rhs_reg);
        cd_t     = {cd_rem_reg, cd_num_reg[CD_DW-1 -: CD_CHUNK]};
        cd_digit = prod_reg[CD_SHIFT +: CD_CHUNK];
        cd_back  = CD_T_W'(cd_digit) * CD_DIVISOR;
        cd_rem   = cd_t - cd_back;
        cd_quo   = {cd_quo_reg[CD_DW-CD_CHUNK-1:0], cd_digit};
    end

    always_comb
    begin
        state_next     = state_reg;
        launch_next    = 1'b0;
        init_next      = init_reg;
        band_next      = band_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        preva_next     = preva_reg;
        prevb_next     = prevb_reg;
        ratio_next     = ratio_reg;
        rela_next      = rela_reg;
        relb_next      = relb_reg;
        factor_next    = factor_reg;
        acc_next       = acc_reg;
        mean_next      = mean_reg;
        dev_next       = dev_reg;
        ex2_next       = ex2_reg;
        msq_next       = msq_reg;
        dev2_next      = dev2_reg;
        var_next       = var_reg;
        sqr_next       = sqr_reg;
        k2_next        = k2_reg;
        rhs_next       = rhs_reg;
        worth_next     = worth_reg;
        held_next      = held_reg;
        ready_res_next = ready_res_reg;
        rsum_next      = rsum_reg;
        ssum_next      = ssum_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cd_num_next    = cd_num_reg;
        cd_quo_next    = cd_quo_reg;
        cd_rem_next    = cd_rem_reg;
        cd_step_next   = cd_step_reg;
        mul_a          = '0;
        mul_b          = '0;
        ram_we         = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_INITIAL_WORTH: init_next = cfg_data;
                CFG_BAND_MULTIPLE: band_next = cfg_data[BAND_W-1:0];
                default:
                begin
                end
            endcase
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    a_next      = s_tdata[PRICE_W-1:0];
                    b_next      = s_tdata[2*PRICE_W-1:PRICE_W];
                    state_next  = S_RATIO;
                    launch_next = 1'b1;
                end
            end
            S_RATIO:
            begin
                if (div_rsp.done)
                begin
                    if (b_reg == '0 || div_rsp.quotient[DIVD_W-1:RATIO_W] != '0)
                    begin
                        ratio_next = '1;
                    end
                    else
                    begin
                        ratio_next = div_rsp.quotient[RATIO_W-1:0];
                    end
                    ready_res_next = full;
                    if (!full)
                    begin
                        worth_next = WORTH_W'(init_reg) << WORTH_FRAC;
                        state_next = S_PUSH0;
                    end
                    else if (held_reg inside {POS_LONG_A, POS_SHORT_A})
                    begin
                        state_next  = S_RELA;
                        launch_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_MEAN;
                    end
                end
            end
            S_RELA:
            begin
                if (div_rsp.done)
                begin
                    rela_next   = (preva_reg == '0) ? '1 : div_rsp.quotient;
                    state_next  = S_RELB;
                    launch_next = 1'b1;
                end
            end
            S_RELB:
            begin
                if (div_rsp.done)
                begin
                    relb_next  = (prevb_reg == '0) ? '1 : div_rsp.quotient;
                    state_next = S_FACT;
                end
            end
            S_FACT:
            begin
                if (plus <= minus)
                begin
                    worth_next = '0;
                    state_next = S_MEAN;
                end
                else
                begin
                    factor_next = plus - minus;
                    state_next  = S_MW0;
                end
            end
            S_MW0:
            begin
                mul_a      = worth_reg[31:0];
                mul_b      = factor_reg[31:0];
                state_next = S_MW1;
            end
            S_MW1:
            begin
                acc_next   = ACC_W'(prod_reg[63:32]);
                mul_a      = RATIO_W'(worth_reg[WORTH_W-1:32]);
                mul_b      = factor_reg[31:0];
                state_next = S_MW2;
            end
            S_MW2:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                mul_a      = worth_reg[31:0];
                mul_b      = RATIO_W'(factor_reg[FAC_W-1:32]);
                state_next = S_MW3;
            end
            S_MW3:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                mul_a      = RATIO_W'(worth_reg[WORTH_W-1:32]);
                mul_b      = RATIO_W'(factor_reg[FAC_W-1:32]);
                state_next = S_MW4;
            end
            S_MW4:
            begin
                if (prod_reg[63:16] != '0 || wsum > ACC_W'({WORTH_W{1'b1}}))
                begin
                    worth_next = '1;
                end
                else
                begin
                    worth_next = wsum[WORTH_W-1:0];
                end
                state_next = S_MEAN;
            end
            S_MEAN, S_EX2:
            begin
                if (cd_step_reg == CD_LOAD)
                begin
                    cd_num_next  = (state_reg == S_MEAN) ? CD_DW'(rsum_reg)
                                                         : CD_DW'(ssum_reg);
                    cd_rem_next  = '0;
                    cd_step_next = cd_step_reg + 1'b1;
                end
                else if (cd_step_reg[0])
                begin
                    mul_a        = RATIO_W'(cd_t);
                    mul_b        = CD_RECIP;
                    cd_step_next = cd_step_reg + 1'b1;
                end
                else
                begin
                    cd_quo_next  = cd_quo;
                    cd_rem_next  = cd_rem[PTR_W-1:0];
                    cd_num_next  = cd_num_reg << CD_CHUNK;
                    cd_step_next = cd_step_reg + 1'b1;
                    if (cd_step_reg == CD_LAST)
                    begin
                        cd_step_next = CD_LOAD;
                        if (state_reg == S_MEAN)
                        begin
                            mean_next  = cd_quo[RATIO_W-1:0];
                            state_next = S_EX2;
                        end
                        else
                        begin
                            ex2_next   = cd_quo[SQ_W-1:0];
                            state_next = S_MSQ;
                        end
                    end
                end
            end
            S_MSQ:
            begin
                mul_a      = mean_reg;
                mul_b      = mean_reg;
                dev_next   = (ratio_reg >= mean_reg) ? ratio_reg - mean_reg
                                                     : mean_reg - ratio_reg;
                state_next = S_DEV2;
            end
            S_DEV2:
            begin
                msq_next   = prod_reg[63:RATIO_FRAC];
                mul_a      = dev_reg;
                mul_b      = dev_reg;
                state_next = S_VAR;
            end
            S_VAR:
            begin
                dev2_next  = prod_reg[63:RATIO_FRAC];
                var_next   = (ex2_reg > msq_reg) ? ex2_reg - msq_reg : '0;
                mul_a      = RATIO_W'(band_reg);
                mul_b      = RATIO_W'(band_reg);
                state_next = S_K2;
            end
            S_K2:
            begin
                k2_next    = prod_reg[K2_W-1:0];
                state_next = S_RHS0;
            end
            S_RHS0:
            begin
                mul_a      = RATIO_W'(k2_reg);
                mul_b      = var_reg[31:0];
                state_next = S_RHS1;
            end
            S_RHS1:
            begin
                acc_next   = ACC_W'(prod_reg);
                mul_a      = RATIO_W'(k2_reg);
                mul_b      = RATIO_W'(var_reg[SQ_W-1:32]);
                state_next = S_RHS2;
            end
            S_RHS2:
            begin
                rhs_next   = RHS_W'(acc_reg) + (RHS_W'(prod_reg[19:0]) << 32);
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (outside && ratio_reg > mean_reg)
                begin
                    held_next = POS_SHORT_A;
                end
                else if (outside && ratio_reg < mean_reg)
                begin
                    held_next = POS_LONG_A;
                end
                else
                begin
                    held_next = POS_FLAT;
                end
                state_next = S_PUSH0;
            end
            S_PUSH0:
            begin
                mul_a      = ratio_reg;
                mul_b      = ratio_reg;
                state_next = S_PUSH1;
            end
            S_PUSH1:
            begin
                sqr_next   = prod_reg[63:RATIO_FRAC];
                rsum_next  = rsum_reg + RSUM_W'(ratio_reg)
                           - (full ? RSUM_W'(old_ratio) : '0);
                mul_a      = old_ratio;
                mul_b      = old_ratio;
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                ssum_next  = ssum_reg + SSUM_W'(sqr_reg)
                           - (full ? SSUM_W'(prod_reg[63:RATIO_FRAC]) : '0);
                ram_we     = 1'b1;
                ptr_next   = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
                fill_next  = full ? fill_reg : fill_reg + 1'b1;
                preva_next = a_reg;
                prevb_next = b_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = OUT_TDATA_W'({ratio_reg, ready_res_reg,
                                                   held_reg, worth_reg});
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            init_reg      <= INIT_WORTH_RST;
            band_reg      <= BAND_RST;
            preva_reg     <= '0;
            prevb_reg     <= '0;
            worth_reg     <= WORTH_W'(INIT_WORTH_RST) << WORTH_FRAC;
            held_reg      <= POS_LONG_A;
            ready_res_reg <= 1'b0;
            rsum_reg      <= '0;
            ssum_reg      <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            cd_step_reg   <= CD_LOAD;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            init_reg      <= init_next;
            band_reg      <= band_next;
            preva_reg     <= preva_next;
            prevb_reg     <= prevb_next;
            worth_reg     <= worth_next;
            held_reg      <= held_next;
            ready_res_reg <= ready_res_next;
            rsum_reg      <= rsum_next;
            ssum_reg      <= ssum_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            cd_step_reg   <= cd_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        ratio_reg    <= ratio_next;
        rela_reg     <= rela_next;
        relb_reg     <= relb_next;
        factor_reg   <= factor_next;
        acc_reg      <= acc_next;
        mean_reg     <= mean_next;
        dev_reg      <= dev_next;
        ex2_reg      <= ex2_next;
        msq_reg      <= msq_next;
        dev2_reg     <= dev2_next;
        var_reg      <= var_next;
        sqr_reg      <= sqr_next;
        k2_reg       <= k2_next;
        rhs_reg      <= rhs_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        cd_num_reg   <= cd_num_next;
        cd_quo_reg   <= cd_quo_next;
        cd_rem_reg   <= cd_rem_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while the sequencer is idle");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("fill count beyond the window");

    a_held_code: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg == POS_FLAT || held_reg == POS_LONG_A || held_reg == POS_SHORT_A)
        else $error("held position outside its codes");

    a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_RATIO || state_reg == S_RELA
                          || state_reg == S_RELB))
        else $error("divider finished outside a division step");

endmodule
`default_nettype wire

### bench/pair_ratio_band_trader_core_test.sv
// Self-checking bench for pair_ratio_band_trader_core: drives daily price pairs, predicts
// each output word in place (ratio ring, worth update, band decision) and compares it.
// Depends on prbt_pkg and the core RTL.
`timescale 1ns / 100ps
module pair_ratio_band_trader_core_test;
    import prbt_pkg::*;

    localparam int WIN = 30;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pair_ratio_band_trader_core #(.WINDOW(WIN)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state.
    logic [15:0] p_init_worth;
    logic [7:0] p_band;
    logic [31:0] p_ring [WIN];
    int p_ptr;
    int p_fill;
    logic [63:0] p_rsum;
    logic [63:0] p_sqsum;
    logic [23:0] p_prev_a;
    logic [23:0] p_prev_b;
    logic [1:0] p_pos;
    logic [47:0] p_worth;

    logic [IN_TDATA_W-1:0] price_queue[$];
    logic [OUT_TDATA_W-1:0] expected_words[$];
    int send_idle_pct;
    int recv_idle_pct;
    bit failed;
    bit in_taken;

    function automatic logic [31:0] price_ratio(logic [23:0] a, logic [23:0] b);
        logic [63:0] q;
        if (b == 0)
            return 32'hFFFFFFFF;
        q = {40'd0, a} << 28;
        q = q / b;
        return (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
    endfunction

    function automatic logic [63:0] sq28(logic [63:0] r);
        logic [127:0] p;
        p = r * r;
        return p[91:28];
    endfunction

    function automatic logic [63:0] rel_q32(logic [23:0] now, logic [23:0] prev);
        if (prev == 0)
            return (64'd1 << 56) - 1;
        return ({40'd0, now} << 32) / prev;
    endfunction

    task automatic predict_day(logic [23:0] a, logic [23:0] b);
        logic [31:0] r;
        logic [63:0] ra, rb, plus, minus, mean, msq, ex2, vr, dev, dev2, k2, lhs, rhs;
        logic [127:0] prod;
        logic ready;
        r = price_ratio(a, b);
        ready = 0;
        if (p_fill < WIN)
            p_worth = {16'd0, p_init_worth, 16'd0};
        else
        begin
            if (p_pos == POS_LONG_A || p_pos == POS_SHORT_A)
            begin
                ra = rel_q32(a, p_prev_a);
                rb = rel_q32(b, p_prev_b);
                plus = (64'd1 << 32) + ((p_pos == POS_LONG_A) ? ra : rb);
                minus = (p_pos == POS_LONG_A) ? rb : ra;
                if (plus <= minus)
                    p_worth = 0;
                else
                begin
                    prod = p_worth * (plus - minus);
                    prod = prod >> 32;
                    p_worth = (prod > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : prod[47:0];
                end
            end
            mean = p_rsum / WIN;
            msq = sq28(mean);
            ex2 = p_sqsum / WIN;
            vr = (ex2 > msq) ? ex2 - msq : 0;
            dev = (r >= mean) ? r - mean : mean - r;
            dev2 = sq28(dev);
            k2 = p_band * p_band;
            lhs = dev2 << 8;
            rhs = k2 * vr;
            if (lhs > rhs && r > mean)
                p_pos = POS_SHORT_A;
            else if (lhs > rhs && r < mean)
                p_pos = POS_LONG_A;
            else
                p_pos = POS_FLAT;
            ready = 1;
        end
        if (p_fill >= WIN)
        begin
            p_rsum -= p_ring[p_ptr];
            p_sqsum -= sq28(p_ring[p_ptr]);
        end
        else
            p_fill++;
        p_rsum += r;
        p_sqsum += sq28(r);
        p_ring[p_ptr] = r;
        p_ptr = (p_ptr + 1 >= WIN) ? 0 : p_ptr + 1;
        p_prev_a = a;
        p_prev_b = b;
        expected_words.push_back({5'd0, r, ready, p_pos, p_worth});
    endtask

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Driver.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (price_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata <= price_queue.pop_front();
                    s_tvalid <= 1;
                end
                else
                    s_tvalid <= 0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Tracks acceptance on the input side for the predictor and the driver.
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            predict_day(s_tdata[23:0], s_tdata[47:24]);
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, m_tdata);
                failed = 1;
            end
            else if (expected_words[0] != m_tdata)
            begin
                $display("%0t: expected %h actual %h", $time, expected_words[0], m_tdata);
                failed = 1;
                void'(expected_words.pop_front());
            end
            else
                void'(expected_words.pop_front());
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 0;
        if (idx == CFG_INITIAL_WORTH)
            p_init_worth = val;
        else if (idx == CFG_BAND_MULTIPLE)
            p_band = val[7:0];
    endtask

    task automatic drain();
        while (price_queue.size() > 0 || s_tvalid || expected_words.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [23:0] rnd_price();
        case ($urandom_range(3))
            0: return 24'($urandom_range(24'hFFFFFF, 1));
            1: return 24'($urandom_range(200, 1));
            default: return 24'($urandom_range(12000, 8000));
        endcase
    endfunction

    // A trading run: mostly a random walk of both prices with occasional jumps.
    task automatic queue_days(int n);
        logic [23:0] a, b;
        a = 24'($urandom_range(20000, 5000));
        b = 24'($urandom_range(20000, 5000));
        repeat (n)
        begin
            if ($urandom_range(19) == 0)
            begin
                a = rnd_price();
                b = rnd_price();
            end
            else
            begin
                a = a + 24'($urandom_range(400)) - 24'd200;
                b = b + 24'($urandom_range(400)) - 24'd200;
                if (a == 0 || a > 24'hF00000) a = 1000;
                if (b == 0 || b > 24'hF00000) b = 1000;
            end
            price_queue.push_back({b, a});
        end
    endtask

    initial
    begin
        failed = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        m_tready = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        send_idle_pct = 28;
        recv_idle_pct = 65;
        p_init_worth = INIT_WORTH_RST;
        p_band = BAND_RST;
        p_ptr = 0;
        p_fill = 0;
        p_rsum = 0;
        p_sqsum = 0;
        p_prev_a = 0;
        p_prev_b = 0;
        p_pos = POS_LONG_A;
        p_worth = {INIT_WORTH_RST, 16'd0};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: price extremes through warm-up, then constant ratio and zero band.
        price_queue.push_back({24'hFFFFFF, 24'h000001});
        price_queue.push_back({24'h000001, 24'hFFFFFF});
        price_queue.push_back({24'hFFFFFF, 24'hFFFFFF});
        price_queue.push_back({24'h000001, 24'h000001});
        price_queue.push_back({24'h555555, 24'hAAAAAA});
        price_queue.push_back({24'hAAAAAA, 24'h555555});
        drain();
        write_reg(CFG_INITIAL_WORTH, 16'd1);
        write_reg(CFG_BAND_MULTIPLE, 16'd0);
        write_reg(2'd3, 16'hFFFF);
        repeat (24) price_queue.push_back({24'd1000, 24'd1000});
        price_queue.push_back({24'd1000, 24'd1001});
        price_queue.push_back({24'd1000, 24'd999});
        drain();

        write_reg(CFG_BAND_MULTIPLE, 16'd255);
        queue_days(300);
        drain();
        write_reg(CFG_INITIAL_WORTH, 16'hFFFF);
        write_reg(CFG_BAND_MULTIPLE, 16'd32);
        send_idle_pct = 65;
        recv_idle_pct = 28;
        queue_days(350);
        drain();
        write_reg(CFG_BAND_MULTIPLE, 16'd8);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_days(350);
        drain();

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

### files.f
design/prbt_pkg.sv
design/prbt_div.sv
design/prbt_ram.sv
design/pair_ratio_band_trader_core.sv
bench/pair_ratio_band_trader_core_test.sv
